[hdl/rgbled_pkg.sv]
`timescale 1ns / 1ps

package rgbled_pkg;

  // request kinds
  localparam logic [2:0] OP_BACKLIGHT = 3'd0;
  localparam logic [2:0] OP_BATTERY   = 3'd1;
  localparam logic [2:0] OP_NOTIFY    = 3'd2;
  localparam logic [2:0] OP_BUTTONS   = 3'd3;
  localparam logic [2:0] OP_ATTENTION = 3'd4;

  // flash modes
  localparam logic [1:0] FLASH_NONE  = 2'd0;
  localparam logic [1:0] FLASH_TIMED = 2'd1;
  localparam logic [1:0] FLASH_HW    = 2'd2;

  // indicator slots
  localparam int unsigned SLOT_BATT   = 0;
  localparam int unsigned SLOT_NOTIFY = 1;
  localparam int unsigned SLOT_ATTN   = 2;
  localparam int unsigned N_SLOTS     = 3;

  // luminance weights
  localparam logic [7:0] LUM_W_RED   = 8'd77;
  localparam logic [7:0] LUM_W_GREEN = 8'd150;
  localparam logic [7:0] LUM_W_BLUE  = 8'd29;

  localparam logic [2:0] SEC_DEFAULT = 3'd2;

  typedef struct packed {
    logic [23:0] rgb;
    logic [1:0]  mode;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } slot_t;

  // packed so that the last field lands in the lowest bits
  typedef struct packed {
    logic [2:0]  unlit_seconds;
    logic [2:0]  lit_seconds;
    logic        blink_blue;
    logic        blink_green;
    logic        blink_red;
    logic [7:0]  led_blue;
    logic [7:0]  led_green;
    logic [7:0]  led_red;
    logic [7:0]  button_level;
    logic [11:0] backlight_level;
  } result_t;

  // exact floor(x / 255) for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  // clamp to 1000..7000 ms, whole seconds
  function automatic logic [2:0] clamp_sec(input logic [15:0] ms);
    logic [2:0] s;
    if (ms < 16'd2000)      s = 3'd1;
    else if (ms < 16'd3000) s = 3'd2;
    else if (ms < 16'd4000) s = 3'd3;
    else if (ms < 16'd5000) s = 3'd4;
    else if (ms < 16'd6000) s = 3'd5;
    else if (ms < 16'd7000) s = 3'd6;
    else                    s = 3'd7;
    return s;
  endfunction

endpackage

[hdl/rgbled_mac.sv]
`timescale 1ns / 1ps

// shared 8x8 multiplier with accumulator
module rgbled_mac (
  input  logic        clk,
  input  logic        clr,
  input  logic [7:0]  op_a,
  input  logic [7:0]  op_b,
  output logic [15:0] prod_r,
  output logic [17:0] acc_r
);

  logic [15:0] prod;
  logic [17:0] acc_nxt;

  assign prod    = op_a * op_b;
  assign acc_nxt = (clr ? 18'd0 : acc_r) + {2'b00, prod};

  always_ff @(posedge clk) begin
    prod_r <= prod;
    acc_r  <= acc_nxt;
  end

endmodule

[hdl/rgbled_fmt.sv]
`timescale 1ns / 1ps

// slot priority and blink pattern
module rgbled_fmt (
  input  rgbled_pkg::slot_t [2:0] slots,
  input  logic [11:0]             panel_level,
  input  logic [7:0]              key_level,
  output rgbled_pkg::result_t     res
);

  rgbled_pkg::slot_t sel;
  logic              blink;

  always_comb begin
    if (slots[rgbled_pkg::SLOT_ATTN].rgb != 24'd0) begin
      sel = slots[rgbled_pkg::SLOT_ATTN];
    end else if (slots[rgbled_pkg::SLOT_NOTIFY].rgb != 24'd0) begin
      sel = slots[rgbled_pkg::SLOT_NOTIFY];
    end else begin
      sel = slots[rgbled_pkg::SLOT_BATT];
    end

    blink = (sel.mode == rgbled_pkg::FLASH_TIMED) && (sel.on_ms != 16'd0)
            && (sel.off_ms != 16'd0);

    res.backlight_level = panel_level;
    res.button_level    = key_level;
    res.led_red         = sel.rgb[23:16];
    res.led_green       = sel.rgb[15:8];
    res.led_blue        = sel.rgb[7:0];
    res.blink_red       = blink && (sel.rgb[23:16] != 8'd0);
    res.blink_green     = blink && (sel.rgb[15:8] != 8'd0);
    res.blink_blue      = blink && (sel.rgb[7:0] != 8'd0);
    res.lit_seconds     = blink ? rgbled_pkg::clamp_sec(sel.on_ms) : rgbled_pkg::SEC_DEFAULT;
    res.unlit_seconds   = blink ? rgbled_pkg::clamp_sec(sel.off_ms) : rgbled_pkg::SEC_DEFAULT;
  end

endmodule

[hdl/rgb_indicator_led_priority_control_unit.sv]
`timescale 1ns / 1ps
// A request is accepted only in idle and runs through accept, four passes through
// the shared 8x8 multiply-accumulate unit (one per colour channel plus a drain
// step), write-back and output load; the load waits while the previous result
// still sits untaken in the output register. No new request is accepted until
// the output load is done. Reset (rst_n low, synchronous): all slots dark
// with mode none, panel and button levels zero, no result pending, ready.

module rgb_indicator_led_priority_control_unit (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [31:0] argb_color, [33:32] flash_mode, [49:34] on_time_ms,
  //           [65:50] off_time_ms, [71:66] zero
  input  logic [71:0] in_tdata,
  // in_tuser: [2:0] op
  input  logic [2:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [11:0] backlight_level, [19:12] button_level, [27:20] led_red,
  //            [35:28] led_green, [43:36] led_blue, [44] blink_red,
  //            [45] blink_green, [46] blink_blue, [49:47] lit_seconds,
  //            [52:50] unlit_seconds, [55:53] zero
  output logic [55:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_WB   = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] step_r, step_nxt;

  // captured request
  logic [2:0]  op_r;
  logic [31:0] color_r;
  logic [1:0]  mode_r;
  logic [15:0] on_r;
  logic [15:0] off_r;

  // scaled notification channels
  logic [7:0] sc_r [3];

  rgbled_pkg::slot_t [2:0] slot_r;
  logic [11:0] panel_r;
  logic [7:0]  key_r;

  rgbled_pkg::result_t res, out_r;
  logic        out_valid_r;

  logic        accept;
  logic        out_load;
  logic [7:0]  mac_a, mac_b;
  logic [15:0] prod_r;
  logic [17:0] acc_r;
  logic [7:0]  div_q;
  logic        alpha_mid;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r};

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        step_nxt = 2'd0;
        if (accept) state_nxt = S_MUL;
      end
      S_MUL: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          state_nxt = S_WB;
          step_nxt  = 2'd0;
        end
      end
      S_WB:  state_nxt = S_OUT;
      S_OUT: if (out_load) state_nxt = S_IDLE;
      default: begin
        state_nxt = S_IDLE;
        step_nxt  = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_tuser;
      color_r <= in_tdata[31:0];
      mode_r  <= in_tdata[33:32];
      on_r    <= in_tdata[49:34];
      off_r   <= in_tdata[65:50];
    end
  end

  // ---- shared multiplier: one channel per step ----
  // backlight uses the luminance weight, notification the alpha byte
  always_comb begin
    mac_a = 8'd0;
    mac_b = 8'd0;
    case (step_r)
      2'd0: begin
        mac_a = color_r[23:16];
        mac_b = (op_r == rgbled_pkg::OP_BACKLIGHT) ? rgbled_pkg::LUM_W_RED : color_r[31:24];
      end
      2'd1: begin
        mac_a = color_r[15:8];
        mac_b = (op_r == rgbled_pkg::OP_BACKLIGHT) ? rgbled_pkg::LUM_W_GREEN : color_r[31:24];
      end
      2'd2: begin
        mac_a = color_r[7:0];
        mac_b = (op_r == rgbled_pkg::OP_BACKLIGHT) ? rgbled_pkg::LUM_W_BLUE : color_r[31:24];
      end
      default: begin
        mac_a = 8'd0;
        mac_b = 8'd0;
      end
    endcase
  end

  rgbled_mac u_mac (
    .clk    (clk),
    .clr    (step_r == 2'd0),
    .op_a   (mac_a),
    .op_b   (mac_b),
    .prod_r (prod_r),
    .acc_r  (acc_r)
  );

  // product of the previous step, divided by 255
  assign div_q = rgbled_pkg::div255(prod_r);

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      case (step_r)
        2'd1:    sc_r[0] <= div_q;
        2'd2:    sc_r[1] <= div_q;
        2'd3:    sc_r[2] <= div_q;
        default: ;
      endcase
    end
  end

  assign alpha_mid = (color_r[31:24] != 8'h00) && (color_r[31:24] != 8'hff);

  // ---- write-back into slot and level state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      panel_r <= 12'd0;
      key_r   <= 8'd0;
    end else if (state_r == S_WB) begin
      case (op_r)
        rgbled_pkg::OP_BACKLIGHT: panel_r <= {acc_r[15:8], 4'h0};
        rgbled_pkg::OP_BATTERY: begin
          slot_r[rgbled_pkg::SLOT_BATT].rgb    <= color_r[23:0];
          slot_r[rgbled_pkg::SLOT_BATT].mode   <= mode_r;
          slot_r[rgbled_pkg::SLOT_BATT].on_ms  <= on_r;
          slot_r[rgbled_pkg::SLOT_BATT].off_ms <= off_r;
        end
        rgbled_pkg::OP_NOTIFY: begin
          slot_r[rgbled_pkg::SLOT_NOTIFY].rgb    <= alpha_mid ?
                                                   {sc_r[0], sc_r[1], sc_r[2]} : color_r[23:0];
          slot_r[rgbled_pkg::SLOT_NOTIFY].mode   <= mode_r;
          slot_r[rgbled_pkg::SLOT_NOTIFY].on_ms  <= on_r;
          slot_r[rgbled_pkg::SLOT_NOTIFY].off_ms <= off_r;
        end
        rgbled_pkg::OP_BUTTONS: key_r <= color_r[7:0];
        rgbled_pkg::OP_ATTENTION: begin
          // mode none stores a dark colour; hardware flash with a lit but no dark
          // phase falls back to mode none but keeps the colour
          slot_r[rgbled_pkg::SLOT_ATTN].rgb <= (mode_r == rgbled_pkg::FLASH_NONE) ?
                                               24'd0 : color_r[23:0];
          slot_r[rgbled_pkg::SLOT_ATTN].mode <=
            ((mode_r == rgbled_pkg::FLASH_HW) && (on_r != 16'd0) && (off_r == 16'd0)) ?
            rgbled_pkg::FLASH_NONE : mode_r;
          slot_r[rgbled_pkg::SLOT_ATTN].on_ms  <= on_r;
          slot_r[rgbled_pkg::SLOT_ATTN].off_ms <= off_r;
        end
        default: ;
      endcase
    end
  end

  rgbled_fmt u_fmt (
    .slots       (slot_r),
    .panel_level (panel_r),
    .key_level   (key_r),
    .res         (res)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_r <= res;
  end

  // ---- assertions ----
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a request while busy");

  a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_MUL |-> step_r == 2'd0)
    else $error("step counter running outside multiply phase");

  a_lit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[49:47] != 3'd0) && (out_tdata[52:50] != 3'd0))
    else $error("zero breathing phase on output");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || out_tready)
    else $error("result overwritten before taken");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  // request kinds outside the defined set, and the flash mode outside the defined set
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam logic [1:0] FLASH_RSVD = 2'd3;

  localparam int RANDOM_REQUESTS = 1750;
  localparam int STALL_LIMIT     = 1000;

  // light-state predictor and store of expected indicator results
  class light_scoreboard;
    logic [23:0] slot_rgb [rgbled_pkg::N_SLOTS];
    logic [1:0]  slot_mode [rgbled_pkg::N_SLOTS];
    logic [15:0] slot_on [rgbled_pkg::N_SLOTS];
    logic [15:0] slot_off [rgbled_pkg::N_SLOTS];
    logic [11:0] panel;
    logic [7:0]  keys;
    rgbled_pkg::result_t expected_q[$];
    int          errors;
    int          checked;
    int          kind_count[8];

    function new();
      for (int i = 0; i < rgbled_pkg::N_SLOTS; i++) begin
        slot_rgb[i]  = '0;
        slot_mode[i] = rgbled_pkg::FLASH_NONE;
        slot_on[i]   = '0;
        slot_off[i]  = '0;
      end
      panel = '0;
      keys = '0;
      errors = 0;
      checked = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void store_slot(int unsigned s, logic [23:0] rgb, logic [1:0] mode,
                             logic [15:0] on_ms, logic [15:0] off_ms);
      slot_rgb[s]  = rgb;
      slot_mode[s] = mode;
      slot_on[s]   = on_ms;
      slot_off[s]  = off_ms;
    endfunction

    function logic [2:0] to_seconds(logic [15:0] ms);
      int unsigned v;
      v = ms;
      if (v < 1000) v = 1000;
      else if (v > 7000) v = 7000;
      return 3'(v / 1000);
    endfunction

    function void note_request(logic [2:0] op, logic [31:0] argb, logic [1:0] mode,
                               logic [15:0] on_ms, logic [15:0] off_ms);
      int unsigned r, g, b, a, lum, pick;
      logic        flashing;
      rgbled_pkg::result_t res;
      r = argb[23:16];
      g = argb[15:8];
      b = argb[7:0];
      kind_count[op]++;
      case (op)
        rgbled_pkg::OP_BACKLIGHT: begin
          lum = (rgbled_pkg::LUM_W_RED * r + rgbled_pkg::LUM_W_GREEN * g +
                 rgbled_pkg::LUM_W_BLUE * b) >> 8;
          panel = 12'(lum * 16);
        end
        rgbled_pkg::OP_BATTERY:
          store_slot(rgbled_pkg::SLOT_BATT, argb[23:0], mode, on_ms, off_ms);
        rgbled_pkg::OP_NOTIFY: begin
          a = argb[31:24];
          if (a > 0 && a < 255) begin
            r = (r * a) / 255;
            g = (g * a) / 255;
            b = (b * a) / 255;
          end
          store_slot(rgbled_pkg::SLOT_NOTIFY, {8'(r), 8'(g), 8'(b)}, mode, on_ms, off_ms);
        end
        rgbled_pkg::OP_BUTTONS: keys = argb[7:0];
        rgbled_pkg::OP_ATTENTION: begin
          store_slot(rgbled_pkg::SLOT_ATTN, argb[23:0], mode, on_ms, off_ms);
          if (mode == rgbled_pkg::FLASH_HW) begin
            if (on_ms != 0 && off_ms == 0) begin
              slot_mode[rgbled_pkg::SLOT_ATTN] = rgbled_pkg::FLASH_NONE;
            end
          end else if (mode == rgbled_pkg::FLASH_NONE) begin
            slot_rgb[rgbled_pkg::SLOT_ATTN] = '0;
          end
        end
        default: ;
      endcase

      if (slot_rgb[rgbled_pkg::SLOT_ATTN] != 0) pick = rgbled_pkg::SLOT_ATTN;
      else if (slot_rgb[rgbled_pkg::SLOT_NOTIFY] != 0) pick = rgbled_pkg::SLOT_NOTIFY;
      else pick = rgbled_pkg::SLOT_BATT;

      flashing = slot_mode[pick] == rgbled_pkg::FLASH_TIMED && slot_on[pick] != 0 &&
                 slot_off[pick] != 0;
      res.backlight_level = panel;
      res.button_level    = keys;
      res.led_red         = slot_rgb[pick][23:16];
      res.led_green       = slot_rgb[pick][15:8];
      res.led_blue        = slot_rgb[pick][7:0];
      res.blink_red       = flashing && res.led_red != 0;
      res.blink_green     = flashing && res.led_green != 0;
      res.blink_blue      = flashing && res.led_blue != 0;
      res.lit_seconds     = flashing ? to_seconds(slot_on[pick]) : rgbled_pkg::SEC_DEFAULT;
      res.unlit_seconds   = flashing ? to_seconds(slot_off[pick]) : rgbled_pkg::SEC_DEFAULT;
      expected_q.push_back(res);
    endfunction

    task report(string what, int got, int want);
      errors++;
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    task compare(string what, int got, int want);
      if (got != want) report(what, got, want);
    endtask

    task check_result(rgbled_pkg::result_t got);
      rgbled_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result", got.backlight_level, 0);
      end else begin
        want = expected_q.pop_front();
        checked++;
        compare("backlight_level", got.backlight_level, want.backlight_level);
        compare("button_level", got.button_level, want.button_level);
        compare("led_red", got.led_red, want.led_red);
        compare("led_green", got.led_green, want.led_green);
        compare("led_blue", got.led_blue, want.led_blue);
        compare("blink_red", got.blink_red, want.blink_red);
        compare("blink_green", got.blink_green, want.blink_green);
        compare("blink_blue", got.blink_blue, want.blink_blue);
        compare("lit_seconds", got.lit_seconds, want.lit_seconds);
        compare("unlit_seconds", got.unlit_seconds, want.unlit_seconds);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [71:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;

  light_scoreboard sb = new();
  bit steady = 1'b0;   // both sides run without idling while set
  int idle_cycles = 0;

  rgb_indicator_led_priority_control_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always #5 clk = ~clk;

  // result side: check on handshake, then pick next ready at random unless steady
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(rgbled_pkg::result_t'(out_tdata[52:0]));
    end
    out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 27);
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("[%0t] timeout: nothing moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // offer one request, with an optional random gap before it; the gap
  // reaches past the busy window so the block really sees idle input
  task send(logic [2:0] op, logic [31:0] argb, logic [1:0] mode,
            logic [15:0] on_ms, logic [15:0] off_ms);
    if (!steady && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (!in_tready);
      repeat ($urandom_range(0, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, off_ms, on_ms, mode, argb};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, argb, mode, on_ms, off_ms);
  endtask

  // hold off until every request has been answered
  task drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function logic [15:0] pick_ms();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      8:       return 16'($urandom_range(900, 7100));
      9:       return 16'($urandom);
      default: return 16'($urandom_range(0, 8000));
    endcase
  endfunction

  task send_random();
    logic [2:0]  op;
    logic [31:0] argb;
    logic [1:0]  mode;
    int          sel;
    sel = $urandom_range(99);
    // mostly real requests, a few spare kinds as noise
    if (sel < 8) op = 3'($urandom_range(5, 7));
    else op = 3'($urandom_range(0, 4));
    argb = $urandom;
    case ($urandom_range(9))
      0: argb = argb & 32'hFF000000;            // dark colour, slot falls through
      1: argb[31:24] = 8'h00;                   // alpha bypass
      2: argb[31:24] = 8'hFF;
      default: ;
    endcase
    sel = $urandom_range(9);
    if (sel < 3) mode = rgbled_pkg::FLASH_NONE;
    else if (sel < 7) mode = rgbled_pkg::FLASH_TIMED;
    else if (sel < 9) mode = rgbled_pkg::FLASH_HW;
    else mode = FLASH_RSVD;
    send(op, argb, mode, pick_ms(), pick_ms());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // levels at their extremes, alpha ignored on the backlight
    send(rgbled_pkg::OP_BACKLIGHT, 32'hFFFFFFFF, rgbled_pkg::FLASH_NONE, 16'd0, 16'd0);
    send(rgbled_pkg::OP_BACKLIGHT, 32'h00000000, rgbled_pkg::FLASH_NONE, 16'd0, 16'd0);
    send(rgbled_pkg::OP_BACKLIGHT, 32'h00FF8040, rgbled_pkg::FLASH_TIMED, 16'd1, 16'd1);
    send(rgbled_pkg::OP_BUTTONS, 32'hFFFFFF00, rgbled_pkg::FLASH_NONE, 16'd0, 16'd0);
    send(rgbled_pkg::OP_BUTTONS, 32'h000000FF, rgbled_pkg::FLASH_HW, 16'hFFFF, 16'hFFFF);
    // battery: clamping at and around both limits
    send(rgbled_pkg::OP_BATTERY, 32'h00FF0000, rgbled_pkg::FLASH_TIMED, 16'd500, 16'd500);
    send(rgbled_pkg::OP_BATTERY, 32'h0000FF00, rgbled_pkg::FLASH_TIMED, 16'd1000, 16'd7000);
    send(rgbled_pkg::OP_BATTERY, 32'h000000FF, rgbled_pkg::FLASH_TIMED, 16'd999, 16'd7001);
    // notification: alpha scaling inside the open range, bypass at 0 and 255
    send(rgbled_pkg::OP_NOTIFY, 32'h80FFFFFF, rgbled_pkg::FLASH_TIMED, 16'd0, 16'd3000);
    send(rgbled_pkg::OP_NOTIFY, 32'h01FFFFFF, rgbled_pkg::FLASH_TIMED, 16'd2500, 16'd4999);
    send(rgbled_pkg::OP_NOTIFY, 32'hFEFF7F01, rgbled_pkg::FLASH_TIMED, 16'd6000, 16'd1);
    send(rgbled_pkg::OP_NOTIFY, 32'h00123456, rgbled_pkg::FLASH_TIMED, 16'hFFFF, 16'hFFFF);
    send(rgbled_pkg::OP_NOTIFY, 32'hFFABCDEF, rgbled_pkg::FLASH_HW, 16'd1000, 16'd1000);
    // attention: mode none stores dark, hardware with lit but no dark time drops to none
    send(rgbled_pkg::OP_ATTENTION, 32'hFFFFFFFF, rgbled_pkg::FLASH_NONE, 16'd1000, 16'd1000);
    send(rgbled_pkg::OP_ATTENTION, 32'h00FF00FF, rgbled_pkg::FLASH_HW, 16'd1000, 16'd0);
    send(rgbled_pkg::OP_ATTENTION, 32'h00FFFFFF, rgbled_pkg::FLASH_HW, 16'd0, 16'd0);
    send(rgbled_pkg::OP_ATTENTION, 32'h00010203, rgbled_pkg::FLASH_TIMED, 16'hFFFF, 16'd1);
    send(rgbled_pkg::OP_ATTENTION, 32'h00808080, FLASH_RSVD, 16'd3000, 16'd3000);
    // spare kinds leave the state alone
    send(OP_SPARE_5, 32'hFFFFFFFF, rgbled_pkg::FLASH_TIMED, 16'hFFFF, 16'hFFFF);
    send(OP_SPARE_6, 32'h5A5A5A5A, rgbled_pkg::FLASH_HW, 16'd1234, 16'd0);
    send(OP_SPARE_7, 32'hA5A5A5A5, FLASH_RSVD, 16'd0, 16'd4321);
    // clear attention and notification so battery shows, then a dark battery
    send(rgbled_pkg::OP_ATTENTION, 32'h00000000, rgbled_pkg::FLASH_NONE, 16'd0, 16'd0);
    send(rgbled_pkg::OP_NOTIFY, 32'h80010101, rgbled_pkg::FLASH_TIMED, 16'd2000, 16'd2000);
    send(rgbled_pkg::OP_NOTIFY, 32'h80000000, rgbled_pkg::FLASH_NONE, 16'd0, 16'd0);
    send(rgbled_pkg::OP_BATTERY, 32'hFF000000, rgbled_pkg::FLASH_TIMED, 16'd2000, 16'd2000);
    drain();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      steady = (i >= 700 && i < 1000);
      if (i == 1200) drain();
      send_random();
    end
    steady = 1'b0;
    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d light requests: backlight %0d, battery %0d, notification %0d,",
             sb.kind_count.sum(), sb.kind_count[rgbled_pkg::OP_BACKLIGHT],
             sb.kind_count[rgbled_pkg::OP_BATTERY], sb.kind_count[rgbled_pkg::OP_NOTIFY]);
    $display("buttons %0d, attention %0d, spare kinds %0d; %0d results checked.",
             sb.kind_count[rgbled_pkg::OP_BUTTONS], sb.kind_count[rgbled_pkg::OP_ATTENTION],
             sb.kind_count[OP_SPARE_5] + sb.kind_count[OP_SPARE_6] +
             sb.kind_count[OP_SPARE_7], sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
